### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante |-> cons, checked while out of reset
`define SBID_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sbid assertion failed");

// ante |=> cons, checked while out of reset
`define SBID_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sbid assertion failed");

`endif

### sv/sbid_pkg.sv
`default_nettype none

package sbid_pkg;

  localparam logic [2:0] FMT_R   = 3'd0;
  localparam logic [2:0] FMT_I   = 3'd1;
  localparam logic [2:0] FMT_B   = 3'd2;
  localparam logic [2:0] FMT_S   = 3'd3;
  localparam logic [2:0] FMT_L   = 3'd4;
  localparam logic [2:0] FMT_J   = 3'd5;
  localparam logic [2:0] FMT_U   = 3'd6;
  localparam logic [2:0] FMT_SYS = 3'd7;

  localparam logic [5:0] MN_ADD     = 6'd0;
  localparam logic [5:0] MN_SUB     = 6'd1;
  localparam logic [5:0] MN_JR      = 6'd2;
  localparam logic [5:0] MN_JALR    = 6'd3;
  localparam logic [5:0] MN_SLT     = 6'd4;
  localparam logic [5:0] MN_SLTU    = 6'd5;
  localparam logic [5:0] MN_SLL     = 6'd6;
  localparam logic [5:0] MN_SRL     = 6'd7;
  localparam logic [5:0] MN_SRA     = 6'd8;
  localparam logic [5:0] MN_OR      = 6'd9;
  localparam logic [5:0] MN_AND     = 6'd10;
  localparam logic [5:0] MN_XOR     = 6'd11;
  localparam logic [5:0] MN_MV      = 6'd12;
  localparam logic [5:0] MN_ADDI    = 6'd13;
  localparam logic [5:0] MN_SLTI    = 6'd14;
  localparam logic [5:0] MN_SLTUI   = 6'd15;
  localparam logic [5:0] MN_SLLI    = 6'd16;
  localparam logic [5:0] MN_SRLI    = 6'd17;
  localparam logic [5:0] MN_SRAI    = 6'd18;
  localparam logic [5:0] MN_ORI     = 6'd19;
  localparam logic [5:0] MN_ANDI    = 6'd20;
  localparam logic [5:0] MN_XORI    = 6'd21;
  localparam logic [5:0] MN_LI      = 6'd22;
  localparam logic [5:0] MN_BEQ     = 6'd23;
  localparam logic [5:0] MN_SB      = 6'd31;
  localparam logic [5:0] MN_SW      = 6'd32;
  localparam logic [5:0] MN_LB      = 6'd33;
  localparam logic [5:0] MN_LW      = 6'd34;
  localparam logic [5:0] MN_LBU     = 6'd35;
  localparam logic [5:0] MN_J       = 6'd36;
  localparam logic [5:0] MN_JAL     = 6'd37;
  localparam logic [5:0] MN_LUI     = 6'd38;
  localparam logic [5:0] MN_AUIPC   = 6'd39;
  localparam logic [5:0] MN_UNK_R   = 6'd40;
  localparam logic [5:0] MN_UNK_I   = 6'd41;
  localparam logic [5:0] MN_UNK_S   = 6'd42;
  localparam logic [5:0] MN_UNK_L   = 6'd43;
  localparam logic [5:0] MN_ECALL   = 6'd44;
  localparam logic [5:0] MN_UNK_SYS = 6'd45;

  // R funct4 codes
  localparam logic [3:0] F4_ADD  = 4'd0;
  localparam logic [3:0] F4_SUB  = 4'd1;
  localparam logic [3:0] F4_SLL  = 4'd4;
  localparam logic [3:0] F4_SRL  = 4'd5;
  localparam logic [3:0] F4_SRA  = 4'd6;
  localparam logic [3:0] F4_JR   = 4'd11;
  localparam logic [3:0] F4_JALR = 4'd12;

  // I shift selectors, bits 15:13
  localparam logic [2:0] SID_SLLI = 3'd1;
  localparam logic [2:0] SID_SRLI = 3'd2;
  localparam logic [2:0] SID_SRAI = 3'd4;

  // funct3 codes, bits 5:3 for R and I, bits 12:10 otherwise
  localparam logic [2:0] R_F3_BASE    = 3'd0;
  localparam logic [2:0] R_F3_SLT     = 3'd1;
  localparam logic [2:0] R_F3_SLTU    = 3'd2;
  localparam logic [2:0] R_F3_SHIFT   = 3'd3;
  localparam logic [2:0] R_F3_OR      = 3'd4;
  localparam logic [2:0] R_F3_AND     = 3'd5;
  localparam logic [2:0] R_F3_XOR     = 3'd6;
  localparam logic [2:0] R_F3_MV      = 3'd7;
  localparam logic [2:0] I_F3_ADDI    = 3'd0;
  localparam logic [2:0] I_F3_SLTI    = 3'd1;
  localparam logic [2:0] I_F3_SLTUI   = 3'd2;
  localparam logic [2:0] I_F3_SHIFT   = 3'd3;
  localparam logic [2:0] I_F3_ORI     = 3'd4;
  localparam logic [2:0] I_F3_ANDI    = 3'd5;
  localparam logic [2:0] I_F3_XORI    = 3'd6;
  localparam logic [2:0] I_F3_LI      = 3'd7;
  localparam logic [2:0] B_F3_BZ      = 3'd2;
  localparam logic [2:0] B_F3_BNZ     = 3'd3;
  localparam logic [2:0] S_F3_SB      = 3'd0;
  localparam logic [2:0] S_F3_SW      = 3'd1;
  localparam logic [2:0] L_F3_LB      = 3'd0;
  localparam logic [2:0] L_F3_LW      = 3'd1;
  localparam logic [2:0] L_F3_LBU     = 3'd4;
  localparam logic [2:0] SYS_F3_ECALL = 3'd0;

  typedef struct packed {
    logic [5:0]         mnemonic;
    logic [2:0]         format;
    logic [2:0]         reg_a;
    logic [2:0]         reg_b;
    logic               has_reg_a;
    logic               has_reg_b;
    logic               has_imm;
    logic signed [15:0] imm_value;
    logic [9:0]         imm_raw;
  } sbid_res_t;

endpackage

`default_nettype wire

### sv/sixteen_bit_instruction_decoder.sv
// Channel  Dir  Ports                                      Beat
// in       in   in_valid, in_stall, in_instr_word          one instruction word
// out      out  out_valid, out_stall, out_mnemonic .. _raw  one decoded result
//
// One beat per cycle sustained while out_stall is low; an accepted word passes through the
// input register, then is decoded into the result register that drives out_valid.
// rst_n is synchronous, active low; it empties both registers.
// out_stall holds the result register; the input register still fills behind it,
// so in_stall rises only when both registers are full and out_stall is high.
`default_nettype none

module sixteen_bit_instruction_decoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        in_instr_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              out_mnemonic,
  output logic [2:0]              out_format,
  output logic [2:0]              out_reg_a,
  output logic [2:0]              out_reg_b,
  output logic                    out_has_reg_a,
  output logic                    out_has_reg_b,
  output logic                    out_has_imm,
  output logic signed [15:0]      out_imm_value,
  output logic [9:0]              out_imm_raw
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [15:0]         s1_word_r;
  logic                out_valid_r, out_valid_nxt;
  sbid_pkg::sbid_res_t res_r, res_nxt;
  logic                out_open;
  logic                s1_take;

  assign out_open = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_open;
  assign s1_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_open) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_word_r <= in_instr_word;
    end
    if (out_open && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  // decode
  logic [15:0] w;
  logic [2:0]  f3_lo;
  logic [2:0]  f3_hi;
  logic [3:0]  f4;

  assign w     = s1_word_r;
  assign f3_lo = w[5:3];
  assign f3_hi = w[12:10];
  assign f4    = w[15:12];

  always_comb begin
    res_nxt           = '0;
    res_nxt.format    = w[2:0];
    unique case (w[2:0])
      sbid_pkg::FMT_R: begin
        res_nxt.reg_a     = w[8:6];
        res_nxt.reg_b     = w[11:9];
        res_nxt.has_reg_a = 1'b1;
        res_nxt.has_reg_b = 1'b1;
        unique case (f3_lo)
          sbid_pkg::R_F3_BASE: begin
            unique case (f4)
              sbid_pkg::F4_ADD:  res_nxt.mnemonic = sbid_pkg::MN_ADD;
              sbid_pkg::F4_SUB:  res_nxt.mnemonic = sbid_pkg::MN_SUB;
              sbid_pkg::F4_JR: begin
                res_nxt.mnemonic  = sbid_pkg::MN_JR;
                res_nxt.reg_b     = 3'd0;
                res_nxt.has_reg_b = 1'b0;
              end
              sbid_pkg::F4_JALR: res_nxt.mnemonic = sbid_pkg::MN_JALR;
              default:           res_nxt.mnemonic = sbid_pkg::MN_UNK_R;
            endcase
          end
          sbid_pkg::R_F3_SLT:  res_nxt.mnemonic = sbid_pkg::MN_SLT;
          sbid_pkg::R_F3_SLTU: res_nxt.mnemonic = sbid_pkg::MN_SLTU;
          sbid_pkg::R_F3_SHIFT: begin
            unique case (f4)
              sbid_pkg::F4_SLL: res_nxt.mnemonic = sbid_pkg::MN_SLL;
              sbid_pkg::F4_SRL: res_nxt.mnemonic = sbid_pkg::MN_SRL;
              sbid_pkg::F4_SRA: res_nxt.mnemonic = sbid_pkg::MN_SRA;
              default:          res_nxt.mnemonic = sbid_pkg::MN_UNK_R;
            endcase
          end
          sbid_pkg::R_F3_OR:  res_nxt.mnemonic = sbid_pkg::MN_OR;
          sbid_pkg::R_F3_AND: res_nxt.mnemonic = sbid_pkg::MN_AND;
          sbid_pkg::R_F3_XOR: res_nxt.mnemonic = sbid_pkg::MN_XOR;
          sbid_pkg::R_F3_MV:  res_nxt.mnemonic = sbid_pkg::MN_MV;
        endcase
      end
      sbid_pkg::FMT_I: begin
        res_nxt.reg_a     = w[8:6];
        res_nxt.has_reg_a = 1'b1;
        res_nxt.has_imm   = 1'b1;
        res_nxt.imm_raw   = {3'b000, w[15:9]};
        res_nxt.imm_value = {{9{w[15]}}, w[15:9]};
        unique case (f3_lo)
          sbid_pkg::I_F3_ADDI:  res_nxt.mnemonic = sbid_pkg::MN_ADDI;
          sbid_pkg::I_F3_SLTI:  res_nxt.mnemonic = sbid_pkg::MN_SLTI;
          sbid_pkg::I_F3_SLTUI: res_nxt.mnemonic = sbid_pkg::MN_SLTUI;
          sbid_pkg::I_F3_SHIFT: begin
            res_nxt.imm_raw   = {6'b000000, w[12:9]};
            res_nxt.imm_value = {12'h000, w[12:9]};
            unique case (w[15:13])
              sbid_pkg::SID_SLLI: res_nxt.mnemonic = sbid_pkg::MN_SLLI;
              sbid_pkg::SID_SRLI: res_nxt.mnemonic = sbid_pkg::MN_SRLI;
              sbid_pkg::SID_SRAI: res_nxt.mnemonic = sbid_pkg::MN_SRAI;
              default: begin
                res_nxt.mnemonic  = sbid_pkg::MN_UNK_I;
                res_nxt.imm_raw   = {3'b000, w[15:9]};
                res_nxt.imm_value = {{9{w[15]}}, w[15:9]};
              end
            endcase
          end
          sbid_pkg::I_F3_ORI:  res_nxt.mnemonic = sbid_pkg::MN_ORI;
          sbid_pkg::I_F3_ANDI: res_nxt.mnemonic = sbid_pkg::MN_ANDI;
          sbid_pkg::I_F3_XORI: res_nxt.mnemonic = sbid_pkg::MN_XORI;
          sbid_pkg::I_F3_LI:   res_nxt.mnemonic = sbid_pkg::MN_LI;
        endcase
      end
      sbid_pkg::FMT_B: begin
        res_nxt.mnemonic  = sbid_pkg::MN_BEQ + {3'b000, f3_hi};
        res_nxt.reg_a     = w[10:8];
        res_nxt.has_reg_a = 1'b1;
        res_nxt.has_imm   = 1'b1;
        res_nxt.imm_raw   = {5'b00000, w[3:0], 1'b0};
        res_nxt.imm_value = {{11{w[3]}}, w[3:0], 1'b0};
        // BZ and BNZ test one register
        if (f3_hi != sbid_pkg::B_F3_BZ && f3_hi != sbid_pkg::B_F3_BNZ) begin
          res_nxt.reg_b     = w[7:5];
          res_nxt.has_reg_b = 1'b1;
        end
      end
      sbid_pkg::FMT_S: begin
        unique case (f3_hi)
          sbid_pkg::S_F3_SB: res_nxt.mnemonic = sbid_pkg::MN_SB;
          sbid_pkg::S_F3_SW: res_nxt.mnemonic = sbid_pkg::MN_SW;
          default:           res_nxt.mnemonic = sbid_pkg::MN_UNK_S;
        endcase
        res_nxt.reg_a     = w[7:5];
        res_nxt.reg_b     = w[10:8];
        res_nxt.has_reg_a = 1'b1;
        res_nxt.has_reg_b = 1'b1;
        res_nxt.has_imm   = 1'b1;
        res_nxt.imm_raw   = {6'b000000, w[3:0]};
        res_nxt.imm_value = {{12{w[3]}}, w[3:0]};
      end
      sbid_pkg::FMT_L: begin
        unique case (f3_hi)
          sbid_pkg::L_F3_LB:  res_nxt.mnemonic = sbid_pkg::MN_LB;
          sbid_pkg::L_F3_LW:  res_nxt.mnemonic = sbid_pkg::MN_LW;
          sbid_pkg::L_F3_LBU: res_nxt.mnemonic = sbid_pkg::MN_LBU;
          default:            res_nxt.mnemonic = sbid_pkg::MN_UNK_L;
        endcase
        res_nxt.reg_a     = w[10:8];
        res_nxt.reg_b     = w[7:5];
        res_nxt.has_reg_a = 1'b1;
        res_nxt.has_reg_b = 1'b1;
        res_nxt.has_imm   = 1'b1;
        res_nxt.imm_raw   = {6'b000000, w[3:0]};
        res_nxt.imm_value = {{12{w[3]}}, w[3:0]};
      end
      sbid_pkg::FMT_J: begin
        res_nxt.has_imm   = 1'b1;
        res_nxt.imm_raw   = {w[14:9], w[5:3], 1'b0};
        res_nxt.imm_value = {{6{w[14]}}, w[14:9], w[5:3], 1'b0};
        if (w[15]) begin
          res_nxt.mnemonic  = sbid_pkg::MN_JAL;
          res_nxt.reg_a     = w[8:6];
          res_nxt.has_reg_a = 1'b1;
        end else begin
          res_nxt.mnemonic  = sbid_pkg::MN_J;
        end
      end
      sbid_pkg::FMT_U: begin
        res_nxt.mnemonic  = w[15] ? sbid_pkg::MN_AUIPC : sbid_pkg::MN_LUI;
        res_nxt.reg_a     = w[8:6];
        res_nxt.has_reg_a = 1'b1;
        res_nxt.has_imm   = 1'b1;
        res_nxt.imm_raw   = {1'b0, w[14:9], w[5:3]};
        res_nxt.imm_value = {w[14:9], w[5:3], 7'b0000000};
      end
      sbid_pkg::FMT_SYS: begin
        res_nxt.mnemonic  = (f3_hi == sbid_pkg::SYS_F3_ECALL) ? sbid_pkg::MN_ECALL
                                                              : sbid_pkg::MN_UNK_SYS;
        res_nxt.has_imm   = 1'b1;
        res_nxt.imm_raw   = w[9:0];
        res_nxt.imm_value = {6'b000000, w[9:0]};
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_mnemonic  = res_r.mnemonic;
  assign out_format    = res_r.format;
  assign out_reg_a     = res_r.reg_a;
  assign out_reg_b     = res_r.reg_b;
  assign out_has_reg_a = res_r.has_reg_a;
  assign out_has_reg_b = res_r.has_reg_b;
  assign out_has_imm   = res_r.has_imm;
  assign out_imm_value = res_r.imm_value;
  assign out_imm_raw   = res_r.imm_raw;

endmodule

`default_nettype wire

### sv/sbid_checker.sv
`default_nettype none

`include "assert_macros.svh"

module sbid_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [5:0]         out_mnemonic,
  input wire logic [2:0]         out_format,
  input wire logic [2:0]         out_reg_a,
  input wire logic [2:0]         out_reg_b,
  input wire logic               out_has_reg_a,
  input wire logic               out_has_reg_b,
  input wire logic               out_has_imm,
  input wire logic signed [15:0] out_imm_value,
  input wire logic [9:0]         out_imm_raw
);

  logic [43:0] out_beat;
  logic        absent_ok;
  logic        r_ok;
  logic        sys_ok;

  assign out_beat  = {out_mnemonic, out_format, out_reg_a, out_reg_b, out_has_reg_a,
                      out_has_reg_b, out_has_imm, out_imm_value, out_imm_raw};
  assign absent_ok = (out_has_imm || (out_imm_value == 16'sd0 && out_imm_raw == 10'd0)) &&
                     (out_has_reg_a || out_reg_a == 3'd0) &&
                     (out_has_reg_b || out_reg_b == 3'd0);
  assign r_ok      = !out_has_imm && out_has_reg_a && out_mnemonic <= sbid_pkg::MN_UNK_R;
  assign sys_ok    = !out_has_reg_a && !out_has_reg_b &&
                     (out_mnemonic == sbid_pkg::MN_ECALL ||
                      out_mnemonic == sbid_pkg::MN_UNK_SYS);

  `SBID_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_beat))
  `SBID_ASSERT_IMP(a_no_bubble_stall, clk, rst_n, !out_valid, !in_stall)
  `SBID_ASSERT_IMP(a_absent_zero, clk, rst_n, out_valid, absent_ok)
  `SBID_ASSERT_IMP(a_r_no_imm, clk, rst_n, out_valid && out_format == sbid_pkg::FMT_R, r_ok)
  `SBID_ASSERT_IMP(a_sys_no_regs, clk, rst_n, out_valid && out_format == sbid_pkg::FMT_SYS, sys_ok)

endmodule

bind sixteen_bit_instruction_decoder sbid_checker u_sbid_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_mnemonic  (out_mnemonic),
  .out_format    (out_format),
  .out_reg_a     (out_reg_a),
  .out_reg_b     (out_reg_b),
  .out_has_reg_a (out_has_reg_a),
  .out_has_reg_b (out_has_reg_b),
  .out_has_imm   (out_has_imm),
  .out_imm_value (out_imm_value),
  .out_imm_raw   (out_imm_raw)
);

`default_nettype wire
